FILE: design/pcent_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcent_pkg
// Shared types, codes and width helpers for the polygon centroid core.
// ----------------------------------------------------------------------------
package pcent_pkg;

    localparam int COORD_W      = 16;
    localparam int CROSS_TERM_W = 33;   // ax*by - bx*ay
    localparam int SUM_W        = 17;   // ax + bx
    localparam int MOM_TERM_W   = 50;   // (ax + bx) * c
    localparam int MIN_VERTICES = 3;
    localparam int SAT_POS_MAG  = 32767;
    localparam int SAT_NEG_MAG  = 32768;

    typedef enum logic [1:0] {
        RES_OK        = 2'd0,
        RES_FEW       = 2'd1,
        RES_ZERO_AREA = 2'd2,
        RES_TOO_MANY  = 2'd3
    } result_code_t;

    // controller -> datapath
    typedef struct packed {
        logic         load;        // latch the accepted vertex word
        logic         take_first;  // first vertex of a polygon
        logic         sat_count;   // vertex beyond the limit
        logic         advance;     // prev <= current, count++
        logic         edge_mul;    // edge step 1: cross products and coordinate sums
        logic         close;       // edge runs back to the first vertex
        logic         edge_sub;    // edge step 2: cross term
        logic         edge_mom;    // edge step 3: moment products, cross accumulate
        logic         edge_acc;    // edge step 4: moment accumulate
        logic         div_load;    // magnitudes and signs
        logic         den_mul3;    // divisor = 3 * |cross|
        logic         div_step;    // one restoring division step
        logic         emit;        // load output register, clear polygon
        result_code_t code;
    } pcent_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic last;
        logic cnt_zero;
        logic cnt_full;
        logic cnt_over;
        logic cnt_few;
        logic cross_zero;
        logic out_free;
    } pcent_sts_t;

    function automatic int edge_w(int max_v);
        return $clog2(max_v);
    endfunction

    function automatic int cross_w(int max_v);
        return CROSS_TERM_W + edge_w(max_v);
    endfunction

    function automatic int mom_w(int max_v);
        return MOM_TERM_W + edge_w(max_v);
    endfunction

endpackage

FILE: design/pcent_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcent_dp
// Vertex registers, shoelace multiply/accumulate, restoring divider and the
// output register.
// ----------------------------------------------------------------------------
module pcent_dp
    import pcent_pkg::*;
#(
    parameter int MAX_VERTICES = 64
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic signed [COORD_W-1:0]  vertex_x,
    input  logic signed [COORD_W-1:0]  vertex_y,
    input  logic                       last_vertex,
    input  pcent_cmd_t                 cmd,
    output pcent_sts_t                 sts,
    input  logic                       out_stall,
    output logic                       out_valid,
    output logic signed [COORD_W-1:0]  center_x,
    output logic signed [COORD_W-1:0]  center_y,
    output logic [1:0]                 status
);

    localparam int CNT_W   = $clog2(MAX_VERTICES + 2);
    localparam int CROSS_W = cross_w(MAX_VERTICES);
    localparam int MOM_W   = mom_w(MAX_VERTICES);
    localparam int NUM_W   = MOM_W;
    localparam int DEN_W   = CROSS_W + 1;

    logic signed [COORD_W-1:0]      cur_x_reg, cur_y_reg;
    logic                           cur_last_reg;
    logic signed [COORD_W-1:0]      first_x_reg, first_y_reg;
    logic signed [COORD_W-1:0]      prev_x_reg, prev_y_reg;
    logic [CNT_W-1:0]               count_reg;
    logic signed [2*COORD_W-1:0]    p1_reg, p2_reg;
    logic signed [SUM_W-1:0]        sx_reg, sy_reg;
    logic signed [CROSS_TERM_W-1:0] c_reg;
    logic signed [MOM_TERM_W-1:0]   mx_prod_reg, my_prod_reg;
    logic signed [CROSS_W-1:0]      cross_reg;
    logic signed [MOM_W-1:0]        mom_x_reg, mom_y_reg;
    logic [CROSS_W-1:0]             abs_cross_reg;
    logic [DEN_W-1:0]               den_reg;
    logic [NUM_W-1:0]               num_x_reg, num_y_reg;
    logic [DEN_W-1:0]               rem_x_reg, rem_y_reg;
    logic                           neg_x_reg, neg_y_reg;
    logic                           out_valid_reg;
    logic signed [COORD_W-1:0]      cx_reg, cy_reg;
    logic [1:0]                     status_reg;

    logic signed [COORD_W-1:0]      bx, by;
    logic [DEN_W:0]                 trial_x, trial_y;
    logic                           qx, qy;
    logic signed [COORD_W-1:0]      sat_x, sat_y;

    // Truncated quotient magnitude plus sign, clamped to the coordinate range.
    function automatic logic signed [COORD_W-1:0] sat_q(logic [NUM_W-1:0] q, logic neg);
        logic signed [COORD_W-1:0] r;
        if (neg) begin
            if (q > NUM_W'(SAT_NEG_MAG)) begin
                r = COORD_W'(-SAT_NEG_MAG);
            end else begin
                r = -$signed(q[COORD_W-1:0]);
            end
        end else begin
            if (q > NUM_W'(SAT_POS_MAG)) begin
                r = COORD_W'(SAT_POS_MAG);
            end else begin
                r = $signed(q[COORD_W-1:0]);
            end
        end
        return r;
    endfunction

    assign bx = cmd.close ? first_x_reg : cur_x_reg;
    assign by = cmd.close ? first_y_reg : cur_y_reg;

    assign trial_x = {rem_x_reg, num_x_reg[NUM_W-1]};
    assign trial_y = {rem_y_reg, num_y_reg[NUM_W-1]};
    assign qx      = (trial_x >= {1'b0, den_reg});
    assign qy      = (trial_y >= {1'b0, den_reg});

    assign sat_x = sat_q(num_x_reg, neg_x_reg);
    assign sat_y = sat_q(num_y_reg, neg_y_reg);

    assign sts.last       = cur_last_reg;
    assign sts.cnt_zero   = (count_reg == '0);
    assign sts.cnt_full   = (count_reg >= CNT_W'(MAX_VERTICES));
    assign sts.cnt_over   = (count_reg > CNT_W'(MAX_VERTICES));
    assign sts.cnt_few    = (count_reg < CNT_W'(MIN_VERTICES));
    assign sts.cross_zero = (cross_reg == '0);
    assign sts.out_free   = !out_valid_reg || !out_stall;

    // polygon state
    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            count_reg <= '0;
            cross_reg <= '0;
            mom_x_reg <= '0;
            mom_y_reg <= '0;
        end else if (cmd.emit) begin
            count_reg <= '0;
            cross_reg <= '0;
            mom_x_reg <= '0;
            mom_y_reg <= '0;
        end else begin
            if (cmd.sat_count) begin
                count_reg <= CNT_W'(MAX_VERTICES + 1);
            end else if (cmd.take_first || cmd.advance) begin
                count_reg <= count_reg + CNT_W'(1);
            end
            if (cmd.edge_mom) begin
                cross_reg <= cross_reg + CROSS_W'(c_reg);
            end
            if (cmd.edge_acc) begin
                mom_x_reg <= mom_x_reg + MOM_W'(mx_prod_reg);
                mom_y_reg <= mom_y_reg + MOM_W'(my_prod_reg);
            end
        end
    end

    // vertex words, edge pipeline and divider
    always_ff @(posedge clk) begin
        if (cmd.load) begin
            cur_x_reg    <= vertex_x;
            cur_y_reg    <= vertex_y;
            cur_last_reg <= last_vertex;
        end
        if (cmd.take_first) begin
            first_x_reg <= cur_x_reg;
            first_y_reg <= cur_y_reg;
        end
        if (cmd.take_first || cmd.advance) begin
            prev_x_reg <= cur_x_reg;
            prev_y_reg <= cur_y_reg;
        end
        if (cmd.edge_mul) begin
            p1_reg <= prev_x_reg * by;
            p2_reg <= bx * prev_y_reg;
            sx_reg <= SUM_W'(prev_x_reg) + SUM_W'(bx);
            sy_reg <= SUM_W'(prev_y_reg) + SUM_W'(by);
        end
        if (cmd.edge_sub) begin
            c_reg <= CROSS_TERM_W'(p1_reg) - CROSS_TERM_W'(p2_reg);
        end
        if (cmd.edge_mom) begin
            mx_prod_reg <= sx_reg * c_reg;
            my_prod_reg <= sy_reg * c_reg;
        end
        if (cmd.div_load) begin
            num_x_reg     <= mom_x_reg[MOM_W-1] ? NUM_W'(-mom_x_reg) : NUM_W'(mom_x_reg);
            num_y_reg     <= mom_y_reg[MOM_W-1] ? NUM_W'(-mom_y_reg) : NUM_W'(mom_y_reg);
            abs_cross_reg <= cross_reg[CROSS_W-1] ? CROSS_W'(-cross_reg)
                                                  : CROSS_W'(cross_reg);
            neg_x_reg     <= mom_x_reg[MOM_W-1] ^ cross_reg[CROSS_W-1];
            neg_y_reg     <= mom_y_reg[MOM_W-1] ^ cross_reg[CROSS_W-1];
            rem_x_reg     <= '0;
            rem_y_reg     <= '0;
        end
        if (cmd.den_mul3) begin
            den_reg <= DEN_W'(abs_cross_reg) + (DEN_W'(abs_cross_reg) << 1);
        end
        if (cmd.div_step) begin
            rem_x_reg <= qx ? DEN_W'(trial_x - {1'b0, den_reg}) : trial_x[DEN_W-1:0];
            rem_y_reg <= qy ? DEN_W'(trial_y - {1'b0, den_reg}) : trial_y[DEN_W-1:0];
            num_x_reg <= {num_x_reg[NUM_W-2:0], qx};
            num_y_reg <= {num_y_reg[NUM_W-2:0], qy};
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.emit) begin
            out_valid_reg <= 1'b1;
        end else if (!out_stall) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk) begin
        if (cmd.emit) begin
            status_reg <= cmd.code;
            if (cmd.code == RES_OK) begin
                cx_reg <= sat_x;
                cy_reg <= sat_y;
            end else begin
                cx_reg <= '0;
                cy_reg <= '0;
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign center_x  = cx_reg;
    assign center_y  = cy_reg;
    assign status    = status_reg;

endmodule

FILE: design/pcent_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcent_ctrl
// Sequencer for vertex intake, edge steps, closing edge and division.
// ----------------------------------------------------------------------------
module pcent_ctrl
    import pcent_pkg::*;
#(
    parameter int MAX_VERTICES = 64
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  pcent_sts_t sts,
    output pcent_cmd_t cmd
);

    localparam int ITER = mom_w(MAX_VERTICES);
    localparam int IT_W = $clog2(ITER);

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECIDE,
        S_E1,
        S_E2,
        S_E3,
        S_E4,
        S_TAIL,
        S_ZCHK,
        S_DEN,
        S_DIV,
        S_RESULT
    } state_t;

    state_t       state_reg, state_next;
    logic         close_reg, close_next;
    result_code_t code_reg, code_next;
    logic [IT_W-1:0] iter_reg, iter_next;

    assign in_stall = (state_reg != S_IDLE);

    always_comb begin
        state_next = state_reg;
        close_next = close_reg;
        code_next  = code_reg;
        iter_next  = iter_reg;
        cmd        = '0;
        cmd.close  = close_reg;
        cmd.code   = code_reg;

        case (state_reg)
            S_IDLE: begin
                if (in_valid) begin
                    cmd.load   = 1'b1;
                    state_next = S_DECIDE;
                end
            end
            S_DECIDE: begin
                if (sts.cnt_full) begin
                    cmd.sat_count = 1'b1;
                    state_next    = S_TAIL;
                end else if (sts.cnt_zero) begin
                    cmd.take_first = 1'b1;
                    state_next     = S_TAIL;
                end else begin
                    close_next = 1'b0;
                    state_next = S_E1;
                end
            end
            S_E1: begin
                cmd.edge_mul = 1'b1;
                state_next   = S_E2;
            end
            S_E2: begin
                cmd.edge_sub = 1'b1;
                state_next   = S_E3;
            end
            S_E3: begin
                cmd.edge_mom = 1'b1;
                state_next   = S_E4;
            end
            S_E4: begin
                cmd.edge_acc = 1'b1;
                if (close_reg) begin
                    state_next = S_ZCHK;
                end else begin
                    cmd.advance = 1'b1;
                    state_next  = S_TAIL;
                end
            end
            S_TAIL: begin
                if (!sts.last) begin
                    state_next = S_IDLE;
                end else if (sts.cnt_over) begin
                    code_next  = RES_TOO_MANY;
                    state_next = S_RESULT;
                end else if (sts.cnt_few) begin
                    code_next  = RES_FEW;
                    state_next = S_RESULT;
                end else begin
                    close_next = 1'b1;
                    state_next = S_E1;
                end
            end
            S_ZCHK: begin
                if (sts.cross_zero) begin
                    code_next  = RES_ZERO_AREA;
                    state_next = S_RESULT;
                end else begin
                    cmd.div_load = 1'b1;
                    state_next   = S_DEN;
                end
            end
            S_DEN: begin
                cmd.den_mul3 = 1'b1;
                iter_next    = '0;
                state_next   = S_DIV;
            end
            S_DIV: begin
                cmd.div_step = 1'b1;
                if (iter_reg == IT_W'(ITER - 1)) begin
                    code_next  = RES_OK;
                    state_next = S_RESULT;
                end else begin
                    iter_next = iter_reg + IT_W'(1);
                end
            end
            S_RESULT: begin
                if (sts.out_free) begin
                    cmd.emit   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            state_reg <= S_IDLE;
            close_reg <= 1'b0;
            code_reg  <= RES_OK;
            iter_reg  <= '0;
        end else begin
            state_reg <= state_next;
            close_reg <= close_next;
            code_reg  <= code_next;
            iter_reg  <= iter_next;
        end
    end

endmodule

FILE: design/polygon_centroid_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// polygon_centroid_core
// Shoelace centroid of a polygon streamed in one vertex per word.
// ----------------------------------------------------------------------------
// Vertices enter one word at a time on the input channel; the word with
// last_vertex set closes the polygon, and only that word produces a result
// word: the centroid (moment / (3 * signed cross sum), truncated toward zero
// and clamped to 16 bits) and a status code (ok, fewer than three vertices,
// zero area, too many vertices; the centroid reads 0,0 for every non-ok
// code). Clockwise and counter-clockwise orderings give the same centroid.
// The block works on one vertex at a time. The first vertex of a polygon,
// or a vertex past MAX_VERTICES (ignored, reported as too many), passes
// through the decide and tail states with the input stalled; every other
// vertex also runs one edge through the 4-step multiply/accumulate sequence
// between those states, with the input stalled throughout. The last
// vertex of a valid polygon also runs the closing edge and, unless the area
// is zero, a restoring divider that resolves one quotient bit per cycle for
// both coordinates at once, 50 + clog2(MAX_VERTICES) steps (56 at the
// default), before the result is registered. The result waits in an output
// register, so the next polygon's vertices are taken while it is stalled
// downstream; a second result waits until the first one is gone.
// ----------------------------------------------------------------------------
module polygon_centroid_core
    import pcent_pkg::*;
#(
    parameter int MAX_VERTICES = 64
) (
    input  logic                      clk,
    input  logic                      rst_n,
    // vertex channel
    input  logic                      in_valid,
    output logic                      in_stall,
    input  logic signed [COORD_W-1:0] vertex_x,
    input  logic signed [COORD_W-1:0] vertex_y,
    input  logic                      last_vertex,
    // result channel
    output logic                      out_valid,
    input  logic                      out_stall,
    output logic signed [COORD_W-1:0] center_x,
    output logic signed [COORD_W-1:0] center_y,
    output logic [1:0]                status
);

    pcent_cmd_t cmd;
    pcent_sts_t sts;

    // sequencer: decides which edge step, division step or result load runs
    pcent_ctrl #(
        .MAX_VERTICES (MAX_VERTICES)
    ) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .sts      (sts),
        .cmd      (cmd)
    );

    // datapath: vertex registers, accumulators, divider and output register
    pcent_dp #(
        .MAX_VERTICES (MAX_VERTICES)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .vertex_x    (vertex_x),
        .vertex_y    (vertex_y),
        .last_vertex (last_vertex),
        .cmd         (cmd),
        .sts         (sts),
        .out_stall   (out_stall),
        .out_valid   (out_valid),
        .center_x    (center_x),
        .center_y    (center_y),
        .status      (status)
    );

endmodule

FILE: design/pcent_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcent_checker
// Port-level checks for the polygon centroid core, bound to the top level.
// ----------------------------------------------------------------------------
module pcent_checker
    import pcent_pkg::*;
(
    input logic                      clk,
    input logic                      rst_n,
    input logic                      in_valid,
    input logic                      in_stall,
    input logic signed [COORD_W-1:0] vertex_x,
    input logic signed [COORD_W-1:0] vertex_y,
    input logic                      last_vertex,
    input logic                      out_valid,
    input logic                      out_stall,
    input logic signed [COORD_W-1:0] center_x,
    input logic signed [COORD_W-1:0] center_y,
    input logic [1:0]                status
);

    // stalled result word holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(center_x)
            && $stable(center_y) && $stable(status))
        else $error("result word changed while stalled");

    // any failure code carries a zero centroid
    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status != RES_OK) |-> (center_x == '0) && (center_y == '0))
        else $error("non-ok status with nonzero centroid");

    // an accepted vertex word is always followed by a stalled input
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("input not held after accepting a vertex");

    // a new result word is only produced while a vertex is in work
    a_result_from_work: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_stall))
        else $error("result appeared without a vertex in work");

endmodule

bind polygon_centroid_core pcent_checker u_pcent_checker (.*);

FILE: verif/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for polygon_centroid_core: streams polygons in as
// vertex words, predicts the shoelace centroid and status of every closed
// polygon, and compares each result word against the oldest prediction.
// ----------------------------------------------------------------------------
module tb;
    import pcent_pkg::*;

    localparam int MAX_V = 64;

    typedef struct packed {
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic                      last;
    } vertex_word_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] cx;
        logic signed [COORD_W-1:0] cy;
        result_code_t              code;
    } centroid_t;

    // coordinate flavors for random polygons
    typedef enum int {
        SHAPE_WIDE,     // anywhere in the 16-bit range
        SHAPE_NEAR,     // small polygon around a random center
        SHAPE_CORNER,   // extreme coordinate values plus -1, 0 and 1
        SHAPE_LINE      // collinear points, zero area
    } shape_t;

    logic                      clk         = 1'b0;
    logic                      rst_n       = 1'b0;
    logic                      in_valid    = 1'b0;
    logic                      in_stall;
    logic signed [COORD_W-1:0] vertex_x    = '0;
    logic signed [COORD_W-1:0] vertex_y    = '0;
    logic                      last_vertex = 1'b0;
    logic                      out_valid;
    logic                      out_stall   = 1'b0;
    logic signed [COORD_W-1:0] center_x;
    logic signed [COORD_W-1:0] center_y;
    logic [1:0]                status;

    vertex_word_t pending_vertices[$];
    centroid_t    expected_centroids[$];
    int           words_queued   = 0;
    int           mismatch_count = 0;
    int           send_idle_pct  = 0;
    int           recv_idle_pct  = 0;

    // predictor state: the polygon being accumulated
    logic signed [COORD_W-1:0] first_x_q = '0;
    logic signed [COORD_W-1:0] first_y_q = '0;
    logic signed [COORD_W-1:0] prev_x_q  = '0;
    logic signed [COORD_W-1:0] prev_y_q  = '0;
    int unsigned               seen_count = 0;
    longint                    cross_acc  = 0;
    longint                    mom_x_acc  = 0;
    longint                    mom_y_acc  = 0;

    polygon_centroid_core #(
        .MAX_VERTICES(MAX_V)
    ) i_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .vertex_x   (vertex_x),
        .vertex_y   (vertex_y),
        .last_vertex(last_vertex),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .center_x   (center_x),
        .center_y   (center_y),
        .status     (status)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    // edge a -> b: cross term, then both moments weighted by it
    function automatic void add_shoelace_edge(longint ax, longint ay, longint bx, longint by);
        longint c;
        c = ax * by - bx * ay;
        cross_acc += c;
        mom_x_acc += (ax + bx) * c;
        mom_y_acc += (ay + by) * c;
    endfunction

    function automatic logic signed [COORD_W-1:0] clamp16(longint v);
        if (v > longint'(SAT_POS_MAG))
            return COORD_W'(SAT_POS_MAG);
        if (v < -longint'(SAT_NEG_MAG))
            return COORD_W'(-SAT_NEG_MAG);
        return v[COORD_W-1:0];
    endfunction

    // Returns 1 when the word closes a polygon; res then holds its result.
    function automatic bit predict_vertex(input logic signed [COORD_W-1:0] x,
                                          input logic signed [COORD_W-1:0] y,
                                          input logic last,
                                          output centroid_t res);
        longint den;
        res.cx   = '0;
        res.cy   = '0;
        res.code = RES_OK;
        if (seen_count < MAX_V)
        begin
            if (seen_count == 0)
            begin
                first_x_q = x;
                first_y_q = y;
            end
            else
                add_shoelace_edge(prev_x_q, prev_y_q, x, y);
            prev_x_q = x;
            prev_y_q = y;
            seen_count++;
        end
        else
            seen_count = MAX_V + 1;   // extra vertices dropped, count pinned

        if (!last)
            return 1'b0;

        if (seen_count > MAX_V)
            res.code = RES_TOO_MANY;
        else if (seen_count < MIN_VERTICES)
            res.code = RES_FEW;
        else
        begin
            add_shoelace_edge(prev_x_q, prev_y_q, first_x_q, first_y_q);
            if (cross_acc == 0)
                res.code = RES_ZERO_AREA;
            else
            begin
                // signed divide: truncates toward zero, and the sign of
                // the area cancels so winding order does not matter
                den    = 3 * cross_acc;
                res.cx = clamp16(mom_x_acc / den);
                res.cy = clamp16(mom_y_acc / den);
            end
        end

        first_x_q  = '0;
        first_y_q  = '0;
        prev_x_q   = '0;
        prev_y_q   = '0;
        seen_count = 0;
        cross_acc  = 0;
        mom_x_acc  = 0;
        mom_y_acc  = 0;
        return 1'b1;
    endfunction

    task automatic note_mismatch(input string msg);
        mismatch_count++;
        $display("tb: mismatch at %0t ns: %s", $time, msg);
    endtask

    // ------------------------------------------------------------------
    // Driver: presents queued vertex words, feeds accepted ones to the
    // predictor. A stalled word is held unchanged.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        vertex_word_t w;
        centroid_t    c;
        if (rst_n)
        begin
            if (in_valid && !in_stall)
            begin
                if (predict_vertex(vertex_x, vertex_y, last_vertex, c))
                    expected_centroids = {expected_centroids, c};
            end
            if (!in_valid || !in_stall)
            begin
                if (pending_vertices.size() != 0 && $urandom_range(0, 99) >= send_idle_pct)
                begin
                    w = pending_vertices.pop_front();
                    in_valid    <= 1'b1;
                    vertex_x    <= w.x;
                    vertex_y    <= w.y;
                    last_vertex <= w.last;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor: checks each accepted result word, stalls at random.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        centroid_t want;
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                if (expected_centroids.size() == 0)
                    note_mismatch($sformatf("unexpected result %0d,%0d status %0d",
                                            center_x, center_y, status));
                else
                begin
                    want = expected_centroids.pop_front();
                    if (center_x !== want.cx)
                        note_mismatch($sformatf("center_x %0d, want %0d",
                                                center_x, want.cx));
                    if (center_y !== want.cy)
                        note_mismatch($sformatf("center_y %0d, want %0d",
                                                center_y, want.cy));
                    if (status !== want.code)
                        note_mismatch($sformatf("status %0d, want %s",
                                                status, want.code.name()));
                end
            end
            out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
        end
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    task automatic push_word(input int x, input int y, input bit last);
        vertex_word_t w;
        w.x    = x[COORD_W-1:0];
        w.y    = y[COORD_W-1:0];
        w.last = last;
        pending_vertices = {pending_vertices, w};
        words_queued++;
    endtask

    function automatic int corner_coord();
        case ($urandom_range(0, 6))
            0:       return -32768;
            1:       return -32767;
            2:       return -1;
            3:       return 0;
            4:       return 1;
            5:       return 32766;
            default: return 32767;
        endcase
    endfunction

    task automatic queue_polygon(input int n, input shape_t shape);
        int bx, by, dx, dy, x, y;
        bx = $urandom_range(0, 60000) - 30000;
        by = $urandom_range(0, 60000) - 30000;
        dx = $urandom_range(0, 40) - 20;
        dy = $urandom_range(0, 40) - 20;
        if (shape == SHAPE_LINE)
        begin
            bx = $urandom_range(0, 2000) - 1000;
            by = $urandom_range(0, 2000) - 1000;
            if ($urandom_range(0, 3) == 0)
            begin
                dx = 0;   // every vertex on one point
                dy = 0;
            end
        end
        for (int k = 0; k < n; k++)
        begin
            case (shape)
                SHAPE_WIDE:
                begin
                    x = $signed(16'($urandom()));
                    y = $signed(16'($urandom()));
                end
                SHAPE_NEAR:
                begin
                    x = bx + $urandom_range(0, 400) - 200;
                    y = by + $urandom_range(0, 400) - 200;
                end
                SHAPE_CORNER:
                begin
                    x = corner_coord();
                    y = corner_coord();
                end
                default:
                begin
                    x = bx + k * dx;
                    y = by + k * dy;
                end
            endcase
            push_word(x, y, k == n - 1);
        end
    endtask

    task automatic queue_random_until(input int target);
        int     sel;
        int     n;
        shape_t shape;
        while (words_queued < target)
        begin
            sel   = $urandom_range(0, 99);
            shape = shape_t'($urandom_range(0, 2));
            if (sel < 4)
                n = $urandom_range(1, 2);
            else if (sel < 8)
                n = $urandom_range(MAX_V - 1, MAX_V + 6);   // around the limit
            else if (sel < 14)
            begin
                n     = $urandom_range(3, 8);
                shape = SHAPE_LINE;
            end
            else
                n = $urandom_range(3, 10);
            queue_polygon(n, shape);
        end
    endtask

    task automatic wait_drained();
        while (pending_vertices.size() != 0 || in_valid || expected_centroids.size() != 0)
            @(negedge clk);
    endtask

    initial
    begin
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // phase 1: sender idles lightly, receiver stalls heavily
        @(negedge clk);
        send_idle_pct = 27;
        recv_idle_pct = 68;

        // single vertex and two vertices: too few
        push_word(-32768, 32767, 1'b1);
        push_word(32767, -32768, 1'b0);
        push_word(0, 0, 1'b1);
        // plain triangle, both windings
        push_word(0, 0, 1'b0);
        push_word(300, 0, 1'b0);
        push_word(0, 300, 1'b1);
        push_word(0, 0, 1'b0);
        push_word(0, 300, 1'b0);
        push_word(300, 0, 1'b1);
        // collinear: zero area
        push_word(0, 0, 1'b0);
        push_word(10, 10, 1'b0);
        push_word(20, 20, 1'b1);
        // full-range triangle
        push_word(-32768, -32768, 1'b0);
        push_word(32767, -32768, 1'b0);
        push_word(-32768, 32767, 1'b1);
        // near-cancelling bow ties: centroid far outside, clamps high and low
        push_word(0, 0, 1'b0);
        push_word(32767, 32767, 1'b0);
        push_word(32767, 0, 1'b0);
        push_word(0, 32766, 1'b1);
        push_word(0, 0, 1'b0);
        push_word(-32768, -32768, 1'b0);
        push_word(-32768, 0, 1'b0);
        push_word(0, -32767, 1'b1);

        queue_random_until(450);
        wait_drained();

        // phase 2: roles swapped
        send_idle_pct = 68;
        recv_idle_pct = 27;
        queue_random_until(900);
        wait_drained();

        // phase 3: back to back
        send_idle_pct = 0;
        recv_idle_pct = 0;
        queue_random_until(1350);
        wait_drained();

        // catch any stray result after the last one
        repeat (150) @(negedge clk);
        if (mismatch_count == 0)
            $display("tb: done, clean");
        else
            $display("tb: done, errors");
        $finish;
    end

    initial
    begin
        #10_000_000;
        $display("tb: timeout at %0t ns", $time);
        $display("tb: done, errors");
        $finish;
    end

endmodule

FILE: sim.f
design/pcent_pkg.sv
design/pcent_dp.sv
design/pcent_ctrl.sv
design/polygon_centroid_core.sv
design/pcent_checker.sv
verif/tb.sv
